/* sv/sfcc_pkg.sv */
// ----------------------------------------------------------------------------
// sfcc_pkg: shared types and constants for the serial frame checker
// Frame layout positions, marker bytes, command codes, result codes and the
// descriptor handed from the front end to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package sfcc_pkg;

  // Longest frame tracked; the position counter saturates here.
  localparam int MAX_FRAME = 1024;
  localparam int POS_W     = $clog2(MAX_FRAME + 1);

  typedef logic [POS_W-1:0] pos_t;

  // Byte positions inside a frame.
  localparam pos_t IDX_START    = pos_t'(0);
  localparam pos_t IDX_CMD      = pos_t'(1);
  localparam pos_t IDX_CHECK    = pos_t'(3);
  localparam pos_t IDX_MIN_LAST = pos_t'(4);
  localparam pos_t IDX_STATUS   = pos_t'(5);
  localparam pos_t IDX_PAY0     = pos_t'(6);
  localparam pos_t IDX_PAY1     = pos_t'(7);
  localparam pos_t IDX_PAY2     = pos_t'(8);
  localparam pos_t POS_MAX      = pos_t'(MAX_FRAME);

  localparam logic [7:0] START_MARK  = 8'hF0;
  localparam logic [7:0] END_MARK    = 8'hF1;

  localparam logic [7:0] CMD_VEND    = 8'h01;
  localparam logic [7:0] CMD_RESTOCK = 8'h05;
  localparam logic [7:0] CMD_POLL    = 8'h06;
  localparam logic [7:0] CMD_UPGRADE = 8'hA1;

  // Raw status range that maps onto a status code.
  localparam logic [7:0] RAW_STATUS_LO = 8'h02;
  localparam logic [7:0] RAW_STATUS_HI = 8'h07;

  typedef enum logic [2:0] {
    KIND_CHECK_ERR = 3'd0,
    KIND_STATUS    = 3'd1,
    KIND_POLL      = 3'd2,
    KIND_UPGRADE   = 3'd3,
    KIND_UNKNOWN   = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_HAVE_READ  = 3'd0,
    ST_SUCCESS    = 3'd1,
    ST_FAILED     = 3'd2,
    ST_REJECT     = 3'd3,
    ST_CHECK_ERR  = 3'd4,
    ST_FORMAT_ERR = 3'd5,
    ST_NONE       = 3'd6
  } status_t;

  // Classified frame, one queue entry.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] command;
    logic [7:0] raw_status;
    logic [7:0] pay0;
    logic [7:0] pay1;
    logic [7:0] pay2;
  } desc_t;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

/* sv/sfcc_if.sv */
// ----------------------------------------------------------------------------
// sfcc_if: request channels of the serial frame checker
// Received byte channel and classified result channel, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfcc_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_end;

  modport source (output valid, output rx_byte, output frame_end, input ready);
  modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface sfcc_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] command;
  logic [7:0] raw_status;
  logic [2:0] status_code;
  logic       status_ok;
  logic [7:0] upgrade_byte;
  logic [7:0] ver_major;
  logic [7:0] ver_minor;
  logic [7:0] ver_patch;

  modport source (
    output valid, output kind, output command, output raw_status,
    output status_code, output status_ok, output upgrade_byte,
    output ver_major, output ver_minor, output ver_patch,
    input ready
  );
  modport sink (
    input valid, input kind, input command, input raw_status,
    input status_code, input status_ok, input upgrade_byte,
    input ver_major, input ver_minor, input ver_patch,
    output ready
  );
endinterface

`default_nettype wire

/* sv/sfcc_front.sv */
// ----------------------------------------------------------------------------
// sfcc_front: byte tracker and frame classifier
// Counts frame bytes, keeps the 7-bit checksum, captures fields and, while
// driver_ready is set, pushes a classified descriptor into the queue on the last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module sfcc_front (
  input  wire logic              clk,
  input  wire logic              rst,
  sfcc_rx_if.sink                rx,
  input  wire logic              driver_ready,
  input  wire sfcc_pkg::q_stat_t q_stat,
  output logic                   push,
  output sfcc_pkg::desc_t        desc
);
  import sfcc_pkg::*;

  pos_t       pos;
  logic [6:0] sum;
  logic [7:0] start;
  logic [7:0] cmd;
  logic [7:0] chk;
  logic [7:0] status;
  logic [7:0] pay0, pay1, pay2;

  logic       accept;
  logic [7:0] cmd_cur, status_cur, pay0_cur, pay1_cur, pay2_cur;
  logic       frame_ok;
  kind_t      kind;

  assign rx.ready = !q_stat.full;
  assign accept   = rx.valid && rx.ready;

  // Fields as they stand including the byte now arriving.
  assign cmd_cur    = (pos == IDX_CMD)    ? rx.rx_byte : cmd;
  assign status_cur = (pos == IDX_STATUS) ? rx.rx_byte : status;
  assign pay0_cur   = (pos == IDX_PAY0)   ? rx.rx_byte : pay0;
  assign pay1_cur   = (pos == IDX_PAY1)   ? rx.rx_byte : pay1;
  assign pay2_cur   = (pos == IDX_PAY2)   ? rx.rx_byte : pay2;

  assign frame_ok = (pos >= IDX_MIN_LAST) && (pos < POS_MAX) &&
                    (start == START_MARK) && (rx.rx_byte == END_MARK) &&
                    (chk == {1'b0, ~sum});

  always_comb begin
    priority if (!frame_ok) begin
      kind = KIND_CHECK_ERR;
    end else if (cmd_cur == CMD_VEND || cmd_cur == CMD_RESTOCK) begin
      kind = KIND_STATUS;
    end else if (cmd_cur == CMD_POLL) begin
      kind = KIND_POLL;
    end else if (cmd_cur == CMD_UPGRADE) begin
      kind = KIND_UPGRADE;
    end else begin
      kind = KIND_UNKNOWN;
    end
  end

  assign push            = accept && rx.frame_end && driver_ready;
  assign desc.kind       = kind;
  assign desc.command    = cmd_cur;
  assign desc.raw_status = status_cur;
  assign desc.pay0       = pay0_cur;
  assign desc.pay1       = pay1_cur;
  assign desc.pay2       = pay2_cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      sum    <= '0;
      start  <= '0;
      cmd    <= '0;
      chk    <= '0;
      status <= '0;
      pay0   <= '0;
      pay1   <= '0;
      pay2   <= '0;
    end else if (accept) begin
      if (rx.frame_end) begin
        // frame done: every captured field starts over at zero
        pos    <= '0;
        sum    <= '0;
        start  <= '0;
        cmd    <= '0;
        chk    <= '0;
        status <= '0;
        pay0   <= '0;
        pay1   <= '0;
        pay2   <= '0;
      end else begin
        if (pos < POS_MAX) begin
          pos <= pos + pos_t'(1);
        end
        if (pos != IDX_START && pos != IDX_CHECK) begin
          sum <= sum + rx.rx_byte[6:0];
        end
        if (pos == IDX_START) begin
          start <= rx.rx_byte;
        end
        if (pos == IDX_CHECK) begin
          chk <= rx.rx_byte;
        end
        cmd    <= cmd_cur;
        status <= status_cur;
        pay0   <= pay0_cur;
        pay1   <= pay1_cur;
        pay2   <= pay2_cur;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/sfcc_queue.sv */
// ----------------------------------------------------------------------------
// sfcc_queue: descriptor queue between front and back end
// Small circular buffer; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sfcc_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire sfcc_pkg::desc_t   wr_desc,
  input  wire logic              pop,
  output sfcc_pkg::desc_t        rd_desc,
  output sfcc_pkg::q_stat_t      q_stat
);
  import sfcc_pkg::*;

  desc_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign q_stat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign rd_desc      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/sfcc_back.sv */
// ----------------------------------------------------------------------------
// sfcc_back: result formatter and output register
// Maps the status byte, zeroes fields that do not apply to the kind and
// holds the result until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sfcc_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire sfcc_pkg::q_stat_t q_stat,
  input  wire sfcc_pkg::desc_t   desc,
  output logic                   pop,
  sfcc_res_if.source             res
);
  import sfcc_pkg::*;

  logic       valid;
  kind_t      kind;
  logic [7:0] command;
  logic [7:0] raw_status;
  status_t    code;
  logic       ok;
  logic [7:0] upg;
  logic [7:0] vmaj, vmin, vpat;

  status_t    mapped;
  status_t    code_next;
  logic       ok_next;

  assign pop = !q_stat.empty && (!valid || res.ready);

  always_comb begin
    if (desc.raw_status >= RAW_STATUS_LO && desc.raw_status <= RAW_STATUS_HI) begin
      mapped = status_t'(desc.raw_status[2:0] - RAW_STATUS_LO[2:0]);
    end else begin
      mapped = ST_NONE;
    end
    unique case (desc.kind)
      KIND_CHECK_ERR: code_next = ST_CHECK_ERR;
      KIND_STATUS:    code_next = mapped;
      KIND_UNKNOWN:   code_next = ST_FORMAT_ERR;
      default:        code_next = ST_NONE;
    endcase
    ok_next = (desc.kind == KIND_STATUS) &&
              (mapped == ST_HAVE_READ || mapped == ST_SUCCESS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (pop) begin
      valid <= 1'b1;
    end else if (res.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind       <= desc.kind;
      command    <= desc.command;
      raw_status <= desc.raw_status;
      code       <= code_next;
      ok         <= ok_next;
      upg        <= (desc.kind == KIND_UPGRADE) ? desc.pay0 : 8'h00;
      vmaj       <= (desc.kind == KIND_POLL) ? desc.pay0 : 8'h00;
      vmin       <= (desc.kind == KIND_POLL) ? desc.pay1 : 8'h00;
      vpat       <= (desc.kind == KIND_POLL) ? desc.pay2 : 8'h00;
    end
  end

  assign res.valid        = valid;
  assign res.kind         = kind;
  assign res.command      = command;
  assign res.raw_status   = raw_status;
  assign res.status_code  = code;
  assign res.status_ok    = ok;
  assign res.upgrade_byte = upg;
  assign res.ver_major    = vmaj;
  assign res.ver_minor    = vmin;
  assign res.ver_patch    = vpat;

endmodule

`default_nettype wire

/* sv/serial_frame_checker_classifier_top.sv */
// A frame's descriptor is queued on its last byte, then popped into the output register.
// Throughput: one byte per cycle while the two-entry descriptor queue is not
//   full; the tracking front end drops rx.ready only while the queue is full.
// Reset: synchronous, active high; clears frame tracking, driver_ready,
//   the queue and the result valid flag of the output register.
// ----------------------------------------------------------------------------
// serial_frame_checker_classifier_top: serial frame checker and classifier
// Checks markers, length and 7-bit checksum of received frames and gives one
// classified result per frame while driver_ready is set.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_frame_checker_classifier_top (
  input  wire logic  clk,
  input  wire logic  rst,
  sfcc_rx_if.sink    rx,
  sfcc_res_if.source res,
  input  wire logic  cfg_we,
  input  wire logic  cfg_data
);
  import sfcc_pkg::*;

  // single config register: frames end silently while it is low
  logic      driver_ready;

  // front end -> queue
  logic      push;
  desc_t     wr_desc;

  // queue -> back end
  logic      pop;
  desc_t     rd_desc;
  q_stat_t   q_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      driver_ready <= 1'b0;
    end else if (cfg_we) begin
      driver_ready <= cfg_data;
    end
  end

  // Front end: accepts a byte every cycle the queue has room. The queue
  // full flag is decoded from the registered count, so rx.ready has no combinational path from the sink.
  sfcc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .rx           (rx),
    .driver_ready (driver_ready),
    .q_stat       (q_stat),
    .push         (push),
    .desc         (wr_desc)
  );

  // Two entries decouple a stalled sink from the byte stream.
  sfcc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_desc (wr_desc),
    .pop     (pop),
    .rd_desc (rd_desc),
    .q_stat  (q_stat)
  );

  // Back end: status mapping and the output register.
  sfcc_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_stat (q_stat),
    .desc   (rd_desc),
    .pop    (pop),
    .res    (res)
  );

  // A descriptor is never pushed into a full queue.
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("descriptor pushed into full queue");

  // The back end never pops an empty queue.
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_stat.empty |-> !pop)
    else $error("pop from empty queue");

  // No result request is shown right after reset.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !res.valid)
    else $error("result valid after reset");

  // A check error always carries the check error status and no ok flag.
  a_err_code: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.kind == KIND_CHECK_ERR) |->
      (res.status_code == ST_CHECK_ERR && !res.status_ok))
    else $error("check error with wrong status");

endmodule

`default_nettype wire
